/* rtl/twe_pkg.sv */
`timescale 1ns / 1ps

package twe_pkg;

    localparam int TIME_W     = 48;
    localparam int TAG_W      = 32;
    localparam int SIZE_W     = 5;
    localparam int WINDOW_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS = 1'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 32'd5000;
    localparam logic [SIZE_W-1:0]   MIN_HITS_RESET = 5'd3;

    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic [TAG_W-1:0]  hit_tag;
    } t_hit;

endpackage

/* rtl/twe_hit_buffer.sv */
`timescale 1ns / 1ps

module twe_hit_buffer #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  twe_pkg::t_hit            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output twe_pkg::t_hit            o_rd_data
);
    import twe_pkg::*;

    t_hit r_mem [DEPTH];
    t_hit r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/time_window_event_builder.sv */
`timescale 1ns / 1ps

// Time-window event builder.
// Hits (time, tag, end-of-window flag) enter on the input channel, valid/ready.
// The first hit opens an event; a hit joins while |time - opening time| is
// below window_ps, otherwise the open event closes and the hit opens a new one.
// An end-of-window flag closes the event after its own hit. Closed events with
// at least min_hits kept hits leave on the output channel, one transaction per
// hit in arrival order, with event size, overflow flag and a last marker.
// Configuration: index 0 = window_ps, index 1 = min_hits; writes always taken.
// A hit that emits nothing is accepted and then evaluated together with its
// buffer write. Closing an event starts with a buffer read, then loads each
// emitted hit into the result register while reading the next, limited by the
// single read port of the hit buffer; a hit that closed the previous event is
// evaluated again afterwards.
// A result register sits on the output: the next hit is accepted while the
// last result of an event still waits. A stalled receiver holds the drain.
// Reset (synchronous, active low) drops any open event and restores
// window_ps = 5000 and min_hits = 3. Buffer contents are not cleared; only
// entries written in the current event are ever read.
module time_window_event_builder #(
    parameter int MAX_EVENT_HITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // hit input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [twe_pkg::TIME_W-1:0]         i_hit_time,
    input  logic [twe_pkg::TAG_W-1:0]          i_hit_tag,
    input  logic                               i_end_of_window,
    // event output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [twe_pkg::TIME_W-1:0]         o_out_time,
    output logic [twe_pkg::TAG_W-1:0]          o_out_tag,
    output logic [twe_pkg::SIZE_W-1:0]         o_event_size,
    output logic                               o_event_overflow,
    output logic                               o_last_of_event,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [twe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [twe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import twe_pkg::*;

    localparam int AW = $clog2(MAX_EVENT_HITS);      // buffer address
    localparam int CW = $clog2(MAX_EVENT_HITS + 1);  // kept-hit count
    localparam int MW = (CW > SIZE_W) ? CW : SIZE_W; // count vs min_hits compare

    typedef enum logic [1:0] {
        S_IDLE,  // waiting for a hit
        S_EVAL,  // window check and buffer write for the held hit
        S_RD,    // first buffer read of a drain
        S_LD     // read data valid, move it to the result register
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [TIME_W-1:0]     r_start, n_start;
    logic [WINDOW_W-1:0]   r_window, n_window;
    logic [SIZE_W-1:0]     r_min_hits, n_min_hits;
    logic                  r_pend, n_pend;     // held hit must be evaluated again
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;

    // held hit and result payload
    t_hit                  r_hit, n_hit;
    logic                  r_hit_eow, n_hit_eow;
    t_hit                  r_out_hit, n_out_hit;
    logic [SIZE_W-1:0]     r_out_size, n_out_size;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    // buffer ports
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_hit                  rd_data;

    logic [TIME_W-1:0]     diff;
    logic                  join_evt;
    logic                  close_old;
    logic [CW-1:0]         cnt_after;
    logic                  drain_last;
    logic [CW+SIZE_W-1:0]  count_ext;

    twe_hit_buffer #(
        .DEPTH (MAX_EVENT_HITS)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_hit),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // event is emitted when it holds hits and reaches min_hits
    function automatic logic emit_ok(input logic [CW-1:0] cnt, input logic [SIZE_W-1:0] mh);
        emit_ok = (cnt != '0) && (MW'(cnt) >= MW'(mh));
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign diff = (r_hit.hit_time >= r_start) ? (r_hit.hit_time - r_start)
                                              : (r_start - r_hit.hit_time);
    assign join_evt  = (r_count != '0) && (diff < TIME_W'(r_window));
    assign close_old = (r_count != '0) && !join_evt;

    assign drain_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign count_ext  = {{SIZE_W{1'b0}}, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_start     = r_start;
        n_window    = r_window;
        n_min_hits  = r_min_hits;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_hit       = r_hit;
        n_hit_eow   = r_hit_eow;
        n_out_hit   = r_out_hit;
        n_out_size  = r_out_size;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        cnt_after   = r_count;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW:   n_window   = i_cfg_data[WINDOW_W-1:0];
                CFG_MIN_HITS: n_min_hits = i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hit.hit_time = i_hit_time;
                    n_hit.hit_tag  = i_hit_tag;
                    n_hit_eow      = i_end_of_window;
                    n_state        = S_EVAL;
                end
            end

            S_EVAL: begin
                if (close_old && emit_ok(r_count, r_min_hits)) begin
                    // drain the old event first, then come back for this hit
                    n_pend  = 1'b1;
                    n_idx   = '0;
                    n_state = S_RD;
                end else begin
                    if (join_evt) begin
                        if (r_count < CW'(MAX_EVENT_HITS)) begin
                            wr_en     = 1'b1;
                            wr_addr   = r_count[AW-1:0];
                            cnt_after = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        // open a new event (old one, if any, discarded)
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        cnt_after = CW'(1);
                        n_ovf     = 1'b0;
                        n_start   = r_hit.hit_time;
                    end
                    n_count = cnt_after;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                    if (r_hit_eow) begin
                        if (emit_ok(cnt_after, r_min_hits)) begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end else begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                    end
                end
            end

            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = S_LD;
            end

            S_LD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = rd_data;
                    n_out_size  = count_ext[SIZE_W-1:0];
                    n_out_ovf   = r_ovf;
                    n_out_last  = drain_last;
                    if (drain_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = r_pend ? S_EVAL : S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + AW'(1);
                        n_idx   = r_idx + AW'(1);
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_start     <= '0;
            r_window    <= WINDOW_RESET;
            r_min_hits  <= MIN_HITS_RESET;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_start     <= n_start;
            r_window    <= n_window;
            r_min_hits  <= n_min_hits;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_hit      <= n_hit;
        r_hit_eow  <= n_hit_eow;
        r_out_hit  <= n_out_hit;
        r_out_size <= n_out_size;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_time       = r_out_hit.hit_time;
    assign o_out_tag        = r_out_hit.hit_tag;
    assign o_event_size     = r_out_size;
    assign o_event_overflow = r_out_ovf;
    assign o_last_of_event  = r_out_last;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    import twe_pkg::*;

    localparam int BUF_DEPTH     = 16;
    // Worst case per hit without stalls: accept, evaluate, a read, a load per
    // emitted hit, re-evaluation and a one-hit drain; plus some margin.
    localparam int SETTLE_CYCLES = BUF_DEPTH + 6 + 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // One hit waiting to be driven
    typedef struct packed {
        logic [TIME_W-1:0] hit_ps;
        logic [TAG_W-1:0]  tag;
        logic              eow;
    } t_hit_item;

    // One emitted hit as the block should present it
    typedef struct packed {
        logic [TIME_W-1:0] out_time;
        logic [TAG_W-1:0]  out_tag;
        logic [SIZE_W-1:0] size;
        logic              overflow;
        logic              last;
    } t_emitted_hit;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [TIME_W-1:0]     i_hit_time = '0;
    logic [TAG_W-1:0]      i_hit_tag = '0;
    logic                  i_end_of_window = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [TIME_W-1:0]     o_out_time;
    logic [TAG_W-1:0]      o_out_tag;
    logic [SIZE_W-1:0]     o_event_size;
    logic                  o_event_overflow;
    logic                  o_last_of_event;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_hit_item    hits_to_send[$];
    t_emitted_hit expected_emissions[$];
    t_hit_item    next_hit;
    t_emitted_hit want;

    int n_errors      = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Running time base for stimulus generation
    logic [TIME_W-1:0] t_now = '0;

    // Predictor state: configuration and the open event
    logic [WINDOW_W-1:0] cfg_window   = WINDOW_RESET;
    logic [SIZE_W-1:0]   cfg_min_hits = MIN_HITS_RESET;
    logic [TIME_W-1:0]   evt_times[BUF_DEPTH];
    logic [TAG_W-1:0]    evt_tags[BUF_DEPTH];
    int                  evt_count    = 0;
    logic [TIME_W-1:0]   evt_start    = '0;
    logic                evt_overflow = 1'b0;

    time_window_event_builder #(
        .MAX_EVENT_HITS(BUF_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_hit_time      (i_hit_time),
        .i_hit_tag       (i_hit_tag),
        .i_end_of_window (i_end_of_window),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_time      (o_out_time),
        .o_out_tag       (o_out_tag),
        .o_event_size    (o_event_size),
        .o_event_overflow(o_event_overflow),
        .o_last_of_event (o_last_of_event),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Event-building predictor
    // ------------------------------------------------------------------

    // Store a hit in the open event, or mark overflow when the buffer is full.
    // A dropped hit leaves the opening time alone.
    task automatic add_to_event(input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag);
        if (evt_count < BUF_DEPTH) begin
            evt_times[evt_count] = t;
            evt_tags[evt_count]  = tag;
            evt_count++;
        end else begin
            evt_overflow = 1'b1;
        end
    endtask

    task automatic start_event(input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag);
        evt_count    = 0;
        evt_overflow = 1'b0;
        evt_start    = t;
        add_to_event(t, tag);
    endtask

    // Close the open event; it is emitted hit by hit only if big enough.
    // min_hits of zero emits everything, above the depth emits nothing.
    task automatic close_event();
        t_emitted_hit e;
        if (evt_count != 0 && evt_count >= int'(cfg_min_hits)) begin
            for (int i = 0; i < evt_count; i++) begin
                e.out_time = evt_times[i];
                e.out_tag  = evt_tags[i];
                e.size     = SIZE_W'(evt_count);
                e.overflow = evt_overflow;
                e.last     = (i == evt_count - 1);
                expected_emissions.insert(expected_emissions.size(), e);
            end
        end
        evt_count    = 0;
        evt_overflow = 1'b0;
    endtask

    // One accepted hit. A hit outside the window closes the old event first,
    // so together with its own end-of-window flag one hit can emit two events.
    task automatic track_hit(input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag,
                             input logic eow);
        logic [TIME_W-1:0] gap;
        if (evt_count == 0) begin
            start_event(t, tag);
        end else begin
            // absolute distance: hits earlier than the opening one may still join
            gap = (t >= evt_start) ? t - evt_start : evt_start - t;
            if (gap < {{(TIME_W - WINDOW_W){1'b0}}, cfg_window}) begin
                add_to_event(t, tag);
            end else begin
                close_event();
                start_event(t, tag);
            end
        end
        if (eow)
            close_event();
    endtask

    // ------------------------------------------------------------------
    // Hit driver: pops the pending queue, predicts on each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready)
            track_hit(i_hit_time, i_hit_tag, i_end_of_window);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            // bus is free (or being freed this edge): maybe present the next hit
            if (hits_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_hit = hits_to_send.pop_front();
                i_in_valid      <= 1'b1;
                i_hit_time      <= next_hit.hit_ps;
                i_hit_tag       <= next_hit.tag;
                i_end_of_window <= next_hit.eow;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // Result monitor: each output transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_emissions.size() == 0) begin
                $error("unexpected result: out_time %h out_tag %h", o_out_time, o_out_tag);
                n_errors++;
            end else begin
                want = expected_emissions.pop_front();
                if (o_out_time !== want.out_time) begin
                    $error("out_time: expected %h, actual %h", want.out_time, o_out_time);
                    n_errors++;
                end
                if (o_out_tag !== want.out_tag) begin
                    $error("out_tag: expected %h, actual %h", want.out_tag, o_out_tag);
                    n_errors++;
                end
                if (o_event_size !== want.size) begin
                    $error("event_size: expected %0d, actual %0d", want.size, o_event_size);
                    n_errors++;
                end
                if (o_event_overflow !== want.overflow) begin
                    $error("event_overflow: expected %b, actual %b",
                           want.overflow, o_event_overflow);
                    n_errors++;
                end
                if (o_last_of_event !== want.last) begin
                    $error("last_of_event: expected %b, actual %b", want.last, o_last_of_event);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_hit(input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag,
                             input logic eow);
        t_hit_item h;
        h.hit_ps = t;
        h.tag    = tag;
        h.eow    = eow;
        hits_to_send.insert(hits_to_send.size(), h);
    endtask

    // Mostly well-formed bursts: small forward steps that keep a hit inside the
    // window, some jumps past it to start the next event, a few steps back
    // and some random jumps anywhere in the time range. The last hit always
    // carries end-of-window so no event stays open across a register write.
    task automatic queue_random_hits(input int count);
        logic [TIME_W-1:0] step_max;
        logic [63:0]       rnd;
        int                r;
        step_max = {{(TIME_W - WINDOW_W){1'b0}}, cfg_window} / 17;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                rnd   = {$urandom, $urandom};
                t_now = rnd[TIME_W-1:0];
            end else if (r < 12) begin
                t_now = t_now - $urandom_range(step_max[31:0]);
            end else if (r < 26) begin
                t_now = t_now + cfg_window + $urandom_range(2000);
            end else begin
                t_now = t_now + $urandom_range(step_max[31:0]);
            end
            queue_hit(t_now, $urandom, ($urandom_range(99) < 9) || (k == count - 1));
        end
    endtask

    // All hits accepted and all predicted results seen
    task automatic wait_drained();
        do @(posedge i_clk);
        while (hits_to_send.size() != 0 || i_in_valid || expected_emissions.size() != 0);
    endtask

    // Drained, plus time for a hit that emits nothing to finish evaluating
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // transaction taken at this edge
        case (idx)
            CFG_WINDOW:   cfg_window   = data[WINDOW_W-1:0];
            CFG_MIN_HITS: cfg_min_hits = data[SIZE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: new settings, then two halves with a full drain in
    // between (sender holds off until every expected result is out).
    task automatic run_phase(input logic [WINDOW_W-1:0] window, input logic [SIZE_W-1:0] min_hits,
                             input int idle_pct, input int stall, input int count);
        write_reg(CFG_WINDOW, CFG_DATA_W'(window));
        write_reg(CFG_MIN_HITS, CFG_DATA_W'(min_hits));
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        queue_random_hits(count / 2);
        wait_drained();
        queue_random_hits(count - count / 2);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (window 5000, min 3): a hit just inside the window
        // joins; extreme tags.
        queue_hit(48'd0, 32'h0000_0000, 1'b0);
        queue_hit(48'd4999, 32'hFFFF_FFFF, 1'b0);
        queue_hit(48'd1, 32'h5A5A_5A5A, 1'b1);
        // Top of the time range; a hit exactly one window away closes the event
        queue_hit(TIME_MAX, 32'hA5A5_A5A5, 1'b0);
        queue_hit(TIME_MAX - 48'd4999, 32'h0F0F_0F0F, 1'b0);
        queue_hit(TIME_MAX - 48'd1, 32'hF0F0_F0F0, 1'b0);
        queue_hit(TIME_MAX - 48'd5000, 32'h1234_5678, 1'b1);
        wait_idle();

        // Zero window with min 1: one hit emits the closed event and its own
        write_reg(CFG_MIN_HITS, CFG_DATA_W'(1));
        write_reg(CFG_WINDOW, CFG_DATA_W'(0));
        queue_hit(48'd7, 32'h0000_0001, 1'b0);
        queue_hit(48'd7, 32'h0000_0002, 1'b1);
        wait_idle();

        // Widest window, min 16: fill the buffer and drop one hit
        write_reg(CFG_WINDOW, '1);
        write_reg(CFG_MIN_HITS, CFG_DATA_W'(BUF_DEPTH));
        for (int k = 0; k < BUF_DEPTH + 1; k++)
            queue_hit(48'd100 + 48'(k), $urandom, k == BUF_DEPTH);
        wait_idle();

        // Random part; the idle profiles rotate across phases
        run_phase(WINDOW_RESET, MIN_HITS_RESET, 0, 0, 70);
        run_phase($urandom_range(20000, 1), 5'd1, 53, 0, 70);
        run_phase('0, 5'd0, 0, 53, 70);           // zero window, every event emitted
        run_phase('1, 5'd16, 22, 22, 70);
        run_phase($urandom, 5'd31, 0, 0, 40);     // min above depth: nothing emitted
        run_phase(32'd1, 5'd2, 53, 0, 50);
        run_phase($urandom_range(100000, 100), 5'd5, 22, 22, 50);

        if (expected_emissions.size() != 0) begin
            $error("%0d expected results never arrived", expected_emissions.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
